FILE: rtl/core/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // queue geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int VAL_W = 32;
    localparam int STAT_W = 2;
    localparam int OUT_CNT_W = 5;

    // operation codes carried in tuser
    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    // controller states: result register empty or holding a word
    typedef enum logic [0:0] {
        S_EMPTY = 1'b0,
        S_HOLD  = 1'b1
    } t_state;

    // command from controller to datapath
    typedef struct packed {
        logic exec;   // run the operation on the input word and load the result
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    output logic                o_m_axis_tvalid,
    input  wire                 i_m_axis_tready,
    output spq_pkg::t_cmd       o_cmd
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake outputs
    always_comb begin
        n_state         = r_state;
        o_m_axis_tvalid = 1'b0;
        o_s_axis_tready = 1'b0;
        o_cmd.exec      = 1'b0;
        unique case (r_state)
            S_EMPTY: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_HOLD;
                end
            end
            S_HOLD: begin
                o_m_axis_tvalid = 1'b1;
                // result leaves while the next word may enter
                o_s_axis_tready = i_m_axis_tready;
                if (i_m_axis_tready) begin
                    if (i_s_axis_tvalid) begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_HOLD;
                    end else begin
                        n_state    = S_EMPTY;
                    end
                end
            end
            default: begin
                n_state = S_EMPTY;
            end
        endcase
        // no input word is taken while reset is held
        if (!i_rst_n) begin
            o_s_axis_tready = 1'b0;
            o_cmd.exec      = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/spq_dpath.sv
`default_nettype none

module spq_dpath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  spq_pkg::t_cmd                       i_cmd,
    input  wire                                 i_kind,
    input  wire signed [spq_pkg::VAL_W-1:0]     i_value,
    input  wire                                 i_cfg_we,
    input  wire        [spq_pkg::CAP_W-1:0]     i_cfg_wdata,
    output logic       [spq_pkg::STAT_W-1:0]    o_status,
    output logic       [spq_pkg::OUT_CNT_W-1:0] o_count,
    output logic signed [spq_pkg::VAL_W-1:0]    o_smallest
);
    import spq_pkg::*;

    // entry cells, count and capacity
    logic signed [VAL_W-1:0] r_entries [DEPTH];
    logic signed [VAL_W-1:0] n_entries [DEPTH];
    logic        [CNT_W-1:0] r_count;
    logic        [CNT_W-1:0] n_count;
    logic        [CAP_W-1:0] r_cap;

    // result register
    logic        [STAT_W-1:0]    r_res_status;
    logic        [OUT_CNT_W-1:0] r_res_count;
    logic signed [VAL_W-1:0]     r_res_smallest;
    t_status                     n_status;

    // per-cell compare flags
    logic [DEPTH-1:0] gt_v;    // cell sits after the insert point
    logic [DEPTH-1:0] eq_v;    // valid cell equal to the value
    logic [DEPTH-1:0] ge_v;    // cell at or after the value
    logic [CMP_W-1:0] limit;
    logic             full;
    logic             found;

    // insert limit saturates at DEPTH
    always_comb begin
        if (CMP_W'(r_cap) > CMP_W'(DEPTH)) begin
            limit = CMP_W'(DEPTH);
        end else begin
            limit = CMP_W'(r_cap);
        end
        full = CMP_W'(r_count) >= limit;
    end

    // parallel compares, one per cell
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) < r_count) begin
                gt_v[i] = r_entries[i] > i_value;
                eq_v[i] = r_entries[i] == i_value;
            end else begin
                gt_v[i] = 1'b1;
                eq_v[i] = 1'b0;
            end
            ge_v[i] = !(i_value > r_entries[i]);
        end
        found = |eq_v;
    end

    // next cell contents, count and status
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
        end
        n_count  = r_count;
        n_status = STAT_DONE;
        if (i_kind == KIND_INSERT) begin
            if (full) begin
                n_status = STAT_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
                // first cell after the insert point takes the value, later ones shift up
                n_entries[0] = gt_v[0] ? i_value : r_entries[0];
                for (int i = 1; i < DEPTH; i++) begin
                    if (gt_v[i] && !gt_v[i-1]) begin
                        n_entries[i] = i_value;
                    end else if (gt_v[i]) begin
                        n_entries[i] = r_entries[i-1];
                    end
                end
            end
        end else begin
            if (!found) begin
                n_status = STAT_NOT_FOUND;
            end else begin
                n_count = r_count - CNT_W'(1);
                // cells from the first match on take their upper neighbor
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (ge_v[i]) begin
                        n_entries[i] = r_entries[i+1];
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_W'(16);
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
        end
    end

    // cells and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= n_entries[i];
            end
            r_res_status <= n_status;
            r_res_count  <= OUT_CNT_W'(n_count);
            if (n_count != '0) begin
                r_res_smallest <= n_entries[0];
            end else begin
                r_res_smallest <= '0;
            end
        end
    end

    assign o_status   = r_res_status;
    assign o_count    = r_res_count;
    assign o_smallest = r_res_smallest;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_unit.sv
`default_nettype none

// Channel   Dir  Ports                          Contents (lowest bit up)
// s_axis    in   tvalid/tready/tdata/tuser      tdata: value[31:0]; tuser: kind[0]
// m_axis    out  tvalid/tready/tdata            status[1:0] count[6:2] smallest[38:7]
// cfg       in   i_cfg_we/i_cfg_wdata           capacity[4:0], no read-back
//
// Each word is compared against all cells at once and the queue updates in the
// cycle it is accepted, when its result is also loaded into the output register.
// One word per cycle is sustained while the sink keeps tready high.
// Reset (i_rst_n low, synchronous) empties the queue and sets capacity to 16.
// A stalled result holds the output register and blocks new input words.

module sorted_priority_queue_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,    // value[31:0]
    input  wire  [0:0]  i_s_axis_tuser,    // kind[0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,    // status[1:0] count[6:2] smallest[38:7] zero[39]
    input  wire         i_cfg_we,
    input  wire  [4:0]  i_cfg_wdata        // capacity[4:0]
);
    import spq_pkg::*;

    t_cmd                     cmd;
    logic [STAT_W-1:0]        res_status;
    logic [OUT_CNT_W-1:0]     res_count;
    logic signed [VAL_W-1:0]  res_smallest;

    // handshake control
    spq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_cmd           (cmd)
    );

    // cells and result register
    spq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_s_axis_tuser[0]),
        .i_value     (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (res_status),
        .o_count     (res_count),
        .o_smallest  (res_smallest)
    );

    // pack result word
    assign o_m_axis_tdata = {1'b0, res_smallest, res_count, res_status};

endmodule

`default_nettype wire
